[design/one_wire_master_top_defines.svh]
// ----------------------------------------------------------------------------
// one_wire_master_top_defines
// Assertion macros shared by the 1-Wire master RTL.
// ----------------------------------------------------------------------------
`ifndef ONE_WIRE_MASTER_TOP_DEFINES_SVH
`define ONE_WIRE_MASTER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// a holds in a cycle -> b holds in the same cycle
`define OWM_ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("owm assertion failed");

// a holds in a cycle -> b holds in the next cycle
`define OWM_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("owm assertion failed");

`else

`define OWM_ASSERT_IMPLY(label, clk, rst_n, a, b)

`define OWM_ASSERT_NEXT(label, clk, rst_n, a, b)

`endif

`endif

[design/owm_pkg.sv]
// ----------------------------------------------------------------------------
// owm_pkg
// Types, operation codes and bus timing constants of the 1-Wire master.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package owm_pkg;

    localparam int TICK_W = 10;

    localparam logic [1:0] OP_IDLE  = 2'd0;
    localparam logic [1:0] OP_RESET = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    localparam logic [1:0] ACT_TICK = 2'd0;

    localparam logic [2:0] PH_LOW    = 3'd0;
    localparam logic [2:0] PH_SAMPLE = 3'd2;

    localparam logic [TICK_W-1:0] RST_LOW_LEN     = 10'd480;
    localparam logic [TICK_W-1:0] RST_WAIT_LEN    = 10'd70;
    localparam logic [TICK_W-1:0] RST_TAIL_LEN    = 10'd410;
    localparam logic [TICK_W-1:0] WR1_LOW_LEN     = 10'd2;
    localparam logic [TICK_W-1:0] WR1_REL_LEN     = 10'd58;
    localparam logic [TICK_W-1:0] WR0_LOW_LEN     = 10'd60;
    localparam logic [TICK_W-1:0] WR0_REL_LEN     = 10'd2;
    localparam logic [TICK_W-1:0] RD_LOW_LEN      = 10'd2;
    localparam logic [TICK_W-1:0] RD_WAIT_LEN     = 10'd10;
    localparam logic [TICK_W-1:0] RD_TAIL_LEN     = 10'd48;
    localparam logic [TICK_W-1:0] NO_PHASE        = 10'd0;

    typedef struct packed {
        logic [1:0]        op;
        logic [2:0]        slot_phase;
        logic [TICK_W-1:0] tick_count;
        logic [2:0]        bit_index;
        logic [7:0]        shift_byte;
        logic              presence;
        logic [7:0]        last_read;
    } owm_state_t;

    typedef struct packed {
        logic drive_low;
        logic done;
        logic rejected;
    } owm_flags_t;

    function automatic logic [TICK_W-1:0] phase_len(input logic [1:0] op,
                                                     input logic [2:0] phase,
                                                     input logic       bit_val);
        logic [TICK_W-1:0] len;
        len = NO_PHASE;
        case (op)
            OP_RESET:
            begin
                if (phase == 3'd0) len = RST_LOW_LEN;
                else if (phase == 3'd1) len = RST_WAIT_LEN;
                else if (phase == 3'd2) len = RST_TAIL_LEN;
            end
            OP_WRITE:
            begin
                if (phase == 3'd0) len = bit_val ? WR1_LOW_LEN : WR0_LOW_LEN;
                else if (phase == 3'd1) len = bit_val ? WR1_REL_LEN : WR0_REL_LEN;
            end
            OP_READ:
            begin
                if (phase == 3'd0) len = RD_LOW_LEN;
                else if (phase == 3'd1) len = RD_WAIT_LEN;
                else if (phase == 3'd2) len = RD_TAIL_LEN;
            end
            default:
            begin
                len = NO_PHASE;
            end
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

[design/owm_step.sv]
// ----------------------------------------------------------------------------
// owm_step
// Next-state and result logic for one request: start commands and ticks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module owm_step (
    input  owm_pkg::owm_state_t state_cur,
    input  logic [1:0]          action,
    input  logic [7:0]          data_byte,
    input  logic                line_level,
    output owm_pkg::owm_state_t state_nxt,
    output owm_pkg::owm_flags_t flags
);
    import owm_pkg::*;

    logic              bit_cur;
    logic [TICK_W-1:0] len_cur;
    logic [TICK_W-1:0] tick_inc;
    logic [2:0]        phase_inc;

    always_comb
    begin
        state_nxt = state_cur;
        flags     = '0;
        bit_cur   = state_cur.shift_byte[state_cur.bit_index];
        len_cur   = phase_len(state_cur.op, state_cur.slot_phase, bit_cur);
        tick_inc  = state_cur.tick_count + 10'd1;
        phase_inc = state_cur.slot_phase + 3'd1;

        if (action != ACT_TICK)
        begin
            if (state_cur.op != OP_IDLE)
            begin
                flags.rejected = 1'b1;
            end
            else
            begin
                state_nxt.op         = action;
                state_nxt.slot_phase = 3'd0;
                state_nxt.tick_count = '0;
                state_nxt.bit_index  = 3'd0;
                state_nxt.shift_byte = (action == OP_WRITE) ? data_byte : 8'd0;
            end
        end
        else if (state_cur.op != OP_IDLE)
        begin
            flags.drive_low = (state_cur.slot_phase == PH_LOW);

            // sample point: presence on reset, data bit on read
            if (state_cur.slot_phase == PH_SAMPLE && state_cur.tick_count == '0)
            begin
                if (state_cur.op == OP_RESET)
                    state_nxt.presence = ~line_level;
                else if (state_cur.op == OP_READ && line_level)
                    state_nxt.shift_byte[state_cur.bit_index] = 1'b1;
            end

            state_nxt.tick_count = tick_inc;
            if (tick_inc >= len_cur)
            begin
                state_nxt.tick_count = '0;
                state_nxt.slot_phase = phase_inc;
                if (phase_len(state_cur.op, phase_inc, bit_cur) == NO_PHASE)
                begin
                    state_nxt.slot_phase = 3'd0;
                    if (state_cur.op == OP_RESET || state_cur.bit_index == 3'd7)
                    begin
                        if (state_cur.op == OP_READ)
                            state_nxt.last_read = state_nxt.shift_byte;
                        state_nxt.op        = OP_IDLE;
                        state_nxt.bit_index = 3'd0;
                        flags.done          = 1'b1;
                    end
                    else
                    begin
                        state_nxt.bit_index = state_cur.bit_index + 3'd1;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

[design/one_wire_master_top.sv]
// ----------------------------------------------------------------------------
// one_wire_master_top
// 1-Wire bus master stepped by one-microsecond tick requests.
// ----------------------------------------------------------------------------
// Each request is a start command (reset, write byte, read byte) or a tick
// carrying the sampled bus level; every request gives exactly one result with
// the drive level for that tick and status. One request is taken per clock
// while the input is not stalled; a request waits in the input register,
// its result is then captured in the result register, and the next request
// may be taken as the previous one advances. A stalled result holds the
// input register, which then stalls the input.
// A start command while an operation runs is flagged rejected and ignored.
`timescale 1ns / 1ps
`default_nettype none
`include "one_wire_master_top_defines.svh"

module one_wire_master_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] action,
    input  logic [7:0] data_byte,
    input  logic       line_level,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       drive_low,
    output logic       busy_res,
    output logic       done_res,
    output logic       presence,
    output logic [7:0] received_byte,
    output logic       rejected
);
    import owm_pkg::*;

    logic       in_valid_reg, in_valid_next;
    logic [1:0] action_reg;
    logic [7:0] data_byte_reg;
    logic       line_level_reg;

    owm_state_t state_reg, state_next;
    owm_flags_t flags;

    logic       out_valid_reg, out_valid_next;
    logic       drive_low_reg, busy_reg, done_reg, rejected_reg;
    logic       presence_reg;
    logic [7:0] received_reg;

    logic advance;
    logic in_load;

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_load  = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_load)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg && out_stall;
        if (advance)
            out_valid_next = 1'b1;
    end

    owm_step u_step (
        .state_cur  (state_reg),
        .action     (action_reg),
        .data_byte  (data_byte_reg),
        .line_level (line_level_reg),
        .state_nxt  (state_next),
        .flags      (flags)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            action_reg     <= action;
            data_byte_reg  <= data_byte;
            line_level_reg <= line_level;
        end
        if (advance)
        begin
            drive_low_reg <= flags.drive_low;
            done_reg      <= flags.done;
            rejected_reg  <= flags.rejected;
            busy_reg      <= (state_next.op != OP_IDLE);
            presence_reg  <= state_next.presence;
            received_reg  <= state_next.last_read;
        end
    end

    assign out_valid     = out_valid_reg;
    assign drive_low     = drive_low_reg;
    assign busy_res      = busy_reg;
    assign done_res      = done_reg;
    assign presence      = presence_reg;
    assign received_byte = received_reg;
    assign rejected      = rejected_reg;

    `OWM_ASSERT_NEXT(a_advance_fills_out, clk, rst_n, advance, out_valid_reg)
    `OWM_ASSERT_IMPLY(a_done_not_busy, clk, rst_n, out_valid_reg && done_reg, !busy_reg)
    `OWM_ASSERT_IMPLY(a_reject_no_drive, clk, rst_n, out_valid_reg && rejected_reg,
                      !drive_low_reg && !done_reg)
    `OWM_ASSERT_IMPLY(a_idle_clean, clk, rst_n, state_reg.op == OP_IDLE,
                      state_reg.slot_phase == 3'd0 && state_reg.tick_count == '0)
    `OWM_ASSERT_IMPLY(a_phase_range, clk, rst_n, 1'b1, state_reg.slot_phase <= PH_SAMPLE)

endmodule

`default_nettype wire

[tb/one_wire_master_top_tb.sv]
// ----------------------------------------------------------------------------
// one_wire_master_top_tb
// Self-checking bench for the tick-stepped 1-Wire bus master.
// ----------------------------------------------------------------------------
// Requests (start commands and microsecond ticks with a sampled bus level)
// are queued up front and sent in random bursts. A bit-level model of the
// master predicts the status of every request, and each result is checked
// against the oldest prediction while the result side stalls in random
// modes. The stimulus covers a reset answered by a device, a write of mixed
// bits, a read of a random line, starts refused while busy and idle ticks.
`timescale 1ns / 1ps

module one_wire_master_top_tb;
    import owm_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LINE_LOW       = 0;
    localparam int LINE_HIGH      = 1;
    localparam int LINE_RANDOM    = 2;

    typedef struct packed {
        logic [1:0] act;
        logic [7:0] data;
        logic       level;
    } bus_request_t;

    typedef struct packed {
        logic       drive;
        logic       busy;
        logic       done;
        logic       pres;
        logic [7:0] rbyte;
        logic       rej;
    } bus_status_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [1:0] action = ACT_TICK;
    logic [7:0] data_byte = 8'h00;
    logic       line_level = 1'b1;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] received_byte;
    logic       rejected;

    bus_request_t request_q[$];
    bus_status_t  bus_status_q[$];
    int           mismatch_count = 0;
    int           idle_cycles = 0;
    int           burst_left = 0;
    int           gap_left = 0;
    int           stall_mode = 0;
    int           stall_run = 0;

    // master model state
    logic [1:0] m_op = OP_IDLE;
    logic [2:0] m_phase = 3'd0;
    logic [9:0] m_ticks = 10'd0;
    logic [2:0] m_bit = 3'd0;
    logic [7:0] m_shift = 8'h00;
    logic       m_pres = 1'b0;
    logic [7:0] m_last = 8'h00;

    one_wire_master_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .data_byte     (data_byte),
        .line_level    (line_level),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .drive_low     (drive_low),
        .busy_res      (busy_res),
        .done_res      (done_res),
        .presence      (presence),
        .received_byte (received_byte),
        .rejected      (rejected)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [9:0] slot_ticks(input logic [1:0] op, input logic [2:0] phase,
                                              input logic bit_val);
        logic [9:0] n;
        n = 10'd0;
        if (op == OP_RESET)
        begin
            if (phase == 3'd0) n = RST_LOW_LEN;
            else if (phase == 3'd1) n = RST_WAIT_LEN;
            else if (phase == 3'd2) n = RST_TAIL_LEN;
        end
        else if (op == OP_WRITE)
        begin
            if (phase == 3'd0) n = bit_val ? WR1_LOW_LEN : WR0_LOW_LEN;
            else if (phase == 3'd1) n = bit_val ? WR1_REL_LEN : WR0_REL_LEN;
        end
        else if (op == OP_READ)
        begin
            if (phase == 3'd0) n = RD_LOW_LEN;
            else if (phase == 3'd1) n = RD_WAIT_LEN;
            else if (phase == 3'd2) n = RD_TAIL_LEN;
        end
        return n;
    endfunction

    task advance_bus_model(input logic [1:0] act, input logic [7:0] data,
                           input logic level, output bus_status_t st);
        logic [9:0] len;
        st = '0;
        if (act != ACT_TICK)
        begin
            if (m_op != OP_IDLE)
                st.rej = 1'b1;
            else
            begin
                m_op = act;
                m_phase = 3'd0;
                m_ticks = 10'd0;
                m_bit = 3'd0;
                m_shift = (act == OP_WRITE) ? data : 8'h00;
            end
        end
        else if (m_op != OP_IDLE)
        begin
            len = slot_ticks(m_op, m_phase, m_shift[m_bit]);
            st.drive = (m_phase == PH_LOW);
            if (m_phase == PH_SAMPLE && m_ticks == 10'd0)
            begin
                if (m_op == OP_RESET)
                    m_pres = !level;
                else if (m_op == OP_READ && level)
                    m_shift[m_bit] = 1'b1;
            end
            m_ticks = m_ticks + 10'd1;
            if (m_ticks >= len)
            begin
                m_ticks = 10'd0;
                m_phase = m_phase + 3'd1;
                if (slot_ticks(m_op, m_phase, m_shift[m_bit]) == 10'd0)
                begin
                    m_phase = 3'd0;
                    if (m_op == OP_RESET || m_bit == 3'd7)
                    begin
                        if (m_op == OP_READ)
                            m_last = m_shift;
                        m_op = OP_IDLE;
                        m_bit = 3'd0;
                        st.done = 1'b1;
                    end
                    else
                        m_bit = m_bit + 3'd1;
                end
            end
        end
        st.busy = (m_op != OP_IDLE);
        st.pres = m_pres;
        st.rbyte = m_last;
    endtask

    task automatic push_request(input logic [1:0] act, input logic [7:0] data,
                                input logic level);
        request_q.push_back('{act: act, data: data, level: level});
    endtask

    // ticks with an occasional refused start mixed in
    task automatic queue_ticks(input int n, input int line_mode, input int noise_pct);
        logic lv;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < noise_pct)
                push_request(2'($urandom_range(1, 3)), 8'($urandom), 1'($urandom));
            lv = (line_mode == LINE_LOW) ? 1'b0 :
                 (line_mode == LINE_HIGH) ? 1'b1 : 1'($urandom);
            push_request(ACT_TICK, 8'($urandom), lv);
        end
    endtask

    task automatic queue_op(input logic [1:0] op, input logic [7:0] val,
                            input int line_mode, input int noise_pct);
        int n;
        n = 0;
        if (op == OP_RESET)
            n = int'(RST_LOW_LEN + RST_WAIT_LEN + RST_TAIL_LEN);
        else if (op == OP_READ)
            n = 8 * int'(RD_LOW_LEN + RD_WAIT_LEN + RD_TAIL_LEN);
        else
            for (int b = 0; b < 8; b++)
                n += int'(val[b] ? (WR1_LOW_LEN + WR1_REL_LEN)
                                 : (WR0_LOW_LEN + WR0_REL_LEN));
        push_request(op, val, 1'($urandom));
        queue_ticks(n, line_mode, noise_pct);
    endtask

    // request driver
    always @(posedge clk)
    begin
        bus_request_t req;
        bus_status_t  st;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                advance_bus_model(action, data_byte, line_level, st);
                bus_status_q.push_back(st);
            end
            if (in_valid && in_stall)
            begin
            end
            else if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left = gap_left - 1;
            end
            else if (request_q.size() != 0)
            begin
                req = request_q.pop_front();
                in_valid <= 1'b1;
                action <= req.act;
                data_byte <= req.data;
                line_level <= req.level;
                if (burst_left <= 1)
                begin
                    burst_left = ($urandom_range(7) == 0) ? $urandom_range(100, 400)
                                                         : $urandom_range(1, 30);
                    gap_left = $urandom_range(0, 5);
                end
                else
                    burst_left = burst_left - 1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result monitor and stall pattern
    always @(posedge clk)
    begin
        bus_status_t want;
        bus_status_t got;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got = {drive_low, busy_res, done_res, presence, received_byte, rejected};
                if (bus_status_q.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: drive=%0d busy=%0d done=%0d",
                                 got.drive, got.busy, got.done,
                                 " pres=%0d byte=%02h rej=%0d",
                                 got.pres, got.rbyte, got.rej);
                end
                else
                begin
                    want = bus_status_q.pop_front();
                    if (got.drive !== want.drive || got.busy !== want.busy ||
                        got.done !== want.done || got.pres !== want.pres ||
                        got.rbyte !== want.rbyte || got.rej !== want.rej)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: exp drive=%0d busy=%0d done=%0d",
                                     want.drive, want.busy, want.done,
                                     " pres=%0d byte=%02h rej=%0d",
                                     want.pres, want.rbyte, want.rej,
                                     ", got drive=%0d busy=%0d done=%0d",
                                     got.drive, got.busy, got.done,
                                     " pres=%0d byte=%02h rej=%0d",
                                     got.pres, got.rbyte, got.rej);
                    end
                end
            end
            if (stall_run == 0)
            begin
                stall_mode = $urandom_range(2);
                stall_run = $urandom_range(20, 200);
            end
            else
                stall_run = stall_run - 1;
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(3) == 0);
                default: out_stall <= ($urandom_range(3) != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        // idle ticks, line level ignored
        push_request(ACT_TICK, 8'h00, 1'b0);
        push_request(ACT_TICK, 8'hFF, 1'b1);
        // reset with a device answering, refused starts right behind the start
        push_request(OP_RESET, 8'h00, 1'b0);
        push_request(OP_WRITE, 8'hFF, 1'b1);
        push_request(OP_READ, 8'h00, 1'b0);
        push_request(OP_RESET, 8'hFF, 1'b1);
        queue_ticks(int'(RST_LOW_LEN + RST_WAIT_LEN + RST_TAIL_LEN), LINE_LOW, 0);
        queue_op(OP_WRITE, 8'hA5, LINE_RANDOM, 1);
        queue_ticks(2, LINE_RANDOM, 0);
        queue_op(OP_READ, 8'h5A, LINE_RANDOM, 1);
        push_request(ACT_TICK, 8'h3C, 1'b0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (request_q.size() != 0 || in_valid || bus_status_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && bus_status_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
